FILE: rtl/scr_pkg.sv
`default_nettype none

package scr_pkg;

   // fixed sizes of the block
   localparam int MAX_COLUMNS = 256;
   localparam int DATA_WIDTH  = 32;
   localparam int COL_W       = $clog2(MAX_COLUMNS);
   localparam int CCOUNT_W    = COL_W + 1;
   localparam int ROW_W       = 16;
   localparam int OP_W        = 3;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   // register indexes of the configuration port
   localparam logic [CSR_INDEX_W-1:0] CSR_REDUCE_OP    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COLUMN_COUNT = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_COUNT    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCALE_FACTOR = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACCUM_MODE   = 3'd4;

   // reduction operation codes
   typedef enum logic [OP_W-1:0] {
      RED_ADD   = 3'd0,
      RED_SQADD = 3'd1,
      RED_MUL   = 3'd2,
      RED_MAX   = 3'd3,
      RED_MIN   = 3'd4,
      RED_LAND  = 3'd5,
      RED_LOR   = 3'd6
   } red_op_type;

   // operations of the shared arithmetic unit
   typedef enum logic [2:0] {
      ALU_ADD,
      ALU_MUL,
      ALU_MAX,
      ALU_MIN,
      ALU_AND,
      ALU_OR
   } alu_op_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SQUARE,
      ST_FOLD,
      ST_STORE,
      ST_UPDATE,
      ST_EMIT
   } seq_state_type;

   // decoded configuration handed to the sequencer
   typedef struct packed {
      logic [OP_W-1:0]       reduce_op;
      logic [COL_W-1:0]      cols_m1;
      logic [ROW_W-1:0]      rows_m1;
      logic [DATA_WIDTH-1:0] scale;
      logic                  accumulate;
   } cfg_type;

   // starting value of an accumulator
   function automatic logic [DATA_WIDTH-1:0] identity_of(input logic [OP_W-1:0] op);
      logic [DATA_WIDTH-1:0] v;
      unique case (op)
         RED_MUL:  v = {{(DATA_WIDTH-1){1'b0}}, 1'b1};
         RED_MAX:  v = {1'b1, {(DATA_WIDTH-1){1'b0}}};
         RED_MIN:  v = {1'b0, {(DATA_WIDTH-1){1'b1}}};
         RED_LAND: v = {{(DATA_WIDTH-1){1'b0}}, 1'b1};
         default:  v = '0;
      endcase
      return v;
   endfunction

   // unit operation that folds one element in
   function automatic alu_op_type fold_op_of(input logic [OP_W-1:0] op);
      alu_op_type f;
      unique case (op)
         RED_MUL:  f = ALU_MUL;
         RED_MAX:  f = ALU_MAX;
         RED_MIN:  f = ALU_MIN;
         RED_LAND: f = ALU_AND;
         RED_LOR:  f = ALU_OR;
         default:  f = ALU_ADD;
      endcase
      return f;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/scr_channels.sv
`default_nettype none

// partial word channel
interface scr_req_if;
   import scr_pkg::*;
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] partial_value;
   logic signed [DATA_WIDTH-1:0] prior_output;
   modport source (output valid, output partial_value, output prior_output, input ready);
   modport sink   (input valid, input partial_value, input prior_output, output ready);
endinterface

// column result channel
interface scr_rsp_if;
   import scr_pkg::*;
   logic                         valid;
   logic                         ready;
   logic [COL_W-1:0]             column_index;
   logic signed [DATA_WIDTH-1:0] result_value;
   logic                         batch_done;
   modport source (output valid, output column_index, output result_value,
                   output batch_done, input ready);
   modport sink   (input valid, input column_index, input result_value,
                   input batch_done, output ready);
endinterface

`default_nettype wire

FILE: rtl/strided_column_reduction_top.sv
// channel  | direction | payload                                    | handshake
// req      | in        | partial_value, prior_output                | valid / ready
// rsp      | out       | column_index, result_value, batch_done     | valid / ready
// csr      | in        | csr_index, csr_wdata                       | csr_we, no wait
//
// a word passes idle (starting the registered ram read), load, square (square-add
// only), fold and store (write-back and scaling); a last-row word then loads the
// output register in emit, after update in accumulate mode, all on one shared alu
// reset is synchronous and clears position, state and output valid; accumulators
// hold no reset value and the first row starts from the identity
// a stalled result waits in the output register while the next word is taken
`default_nettype none

module strided_column_reduction_top (
   input  wire logic                              clock,
   input  wire logic                              reset,
   scr_req_if.sink                                req_chan,
   scr_rsp_if.source                              rsp_chan,
   input  wire logic                              csr_we,
   input  wire logic [scr_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [scr_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import scr_pkg::*;

   logic [OP_W-1:0]       reduce_op_ff;
   logic [CCOUNT_W-1:0]   column_count_ff;
   logic [ROW_W-1:0]      row_count_ff;
   logic [DATA_WIDTH-1:0] scale_ff;
   logic                  accum_ff;
   cfg_type               cfg;
   logic                  seq_ready;
   logic                  seq_valid;
   logic [COL_W-1:0]      seq_column;
   logic [DATA_WIDTH-1:0] seq_result;
   logic                  seq_done;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         reduce_op_ff    <= RED_ADD;
         column_count_ff <= CCOUNT_W'(1);
         row_count_ff    <= ROW_W'(1);
         scale_ff        <= DATA_WIDTH'(1);
         accum_ff        <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_REDUCE_OP:    reduce_op_ff    <= csr_wdata[OP_W-1:0];
            CSR_COLUMN_COUNT: column_count_ff <= csr_wdata[CCOUNT_W-1:0];
            CSR_ROW_COUNT:    row_count_ff    <= csr_wdata[ROW_W-1:0];
            CSR_SCALE_FACTOR: scale_ff        <= csr_wdata[DATA_WIDTH-1:0];
            CSR_ACCUM_MODE:   accum_ff        <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // clamp counts to their last position
   always_comb begin
      cfg.reduce_op  = reduce_op_ff;
      cfg.scale      = scale_ff;
      cfg.accumulate = accum_ff;
      if (column_count_ff == '0) begin
         cfg.cols_m1 = '0;
      end else if (column_count_ff > CCOUNT_W'(MAX_COLUMNS)) begin
         cfg.cols_m1 = COL_W'(MAX_COLUMNS - 1);
      end else begin
         cfg.cols_m1 = COL_W'(column_count_ff - 1'b1);
      end
      cfg.rows_m1 = (row_count_ff == '0) ? '0 : row_count_ff - 1'b1;
   end

   scr_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_valid   (req_chan.valid),
      .req_ready   (seq_ready),
      .req_partial (req_chan.partial_value),
      .req_prior   (req_chan.prior_output),
      .rsp_valid   (seq_valid),
      .rsp_ready   (rsp_chan.ready),
      .rsp_column  (seq_column),
      .rsp_result  (seq_result),
      .rsp_done    (seq_done)
   );

   assign req_chan.ready        = seq_ready;
   assign rsp_chan.valid        = seq_valid;
   assign rsp_chan.column_index = seq_column;
   assign rsp_chan.result_value = seq_result;
   assign rsp_chan.batch_done   = seq_done;

endmodule

`default_nettype wire

FILE: rtl/scr_ram.sv
`default_nettype none

module scr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output      logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

FILE: rtl/scr_alu.sv
`default_nettype none

module scr_alu (
   input  wire scr_pkg::alu_op_type              op,
   input  wire logic [scr_pkg::DATA_WIDTH-1:0]   a,
   input  wire logic [scr_pkg::DATA_WIDTH-1:0]   b,
   output      logic [scr_pkg::DATA_WIDTH-1:0]   y
);
   import scr_pkg::*;

   logic a_true;
   logic b_true;

   assign a_true = (a != '0);
   assign b_true = (b != '0);

   // shared add, multiply, compare and logic unit, wraps to the data width
   always_comb begin
      unique case (op)
         ALU_ADD: y = a + b;
         ALU_MUL: y = a * b;
         ALU_MAX: y = ($signed(a) < $signed(b)) ? b : a;
         ALU_MIN: y = ($signed(b) < $signed(a)) ? b : a;
         ALU_AND: y = {{(DATA_WIDTH-1){1'b0}}, a_true & b_true};
         ALU_OR:  y = {{(DATA_WIDTH-1){1'b0}}, a_true | b_true};
         default: y = a + b;
      endcase
   end

endmodule

`default_nettype wire

FILE: rtl/scr_seq.sv
`default_nettype none

module scr_seq (
   input  wire  logic                              clock,
   input  wire  logic                              reset,
   input  wire  scr_pkg::cfg_type                  cfg,
   input  wire  logic                              req_valid,
   output       logic                              req_ready,
   input  wire  logic [scr_pkg::DATA_WIDTH-1:0]    req_partial,
   input  wire  logic [scr_pkg::DATA_WIDTH-1:0]    req_prior,
   output       logic                              rsp_valid,
   input  wire  logic                              rsp_ready,
   output       logic [scr_pkg::COL_W-1:0]         rsp_column,
   output       logic [scr_pkg::DATA_WIDTH-1:0]    rsp_result,
   output       logic                              rsp_done
);
   import scr_pkg::*;

   seq_state_type         state_ff, state_in;
   logic [COL_W-1:0]      col_pos_ff, col_pos_in;
   logic [ROW_W-1:0]      row_pos_ff, row_pos_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // per-word payload registers
   logic [COL_W-1:0]      col_ff, col_in;
   logic                  last_col_ff, last_col_in;
   logic                  last_row_ff, last_row_in;
   logic                  row_zero_ff, row_zero_in;
   logic [DATA_WIDTH-1:0] v_ff, v_in;
   logic [DATA_WIDTH-1:0] prior_ff, prior_in;
   logic [DATA_WIDTH-1:0] acc_ff, acc_in;
   logic [COL_W-1:0]      rsp_col_ff, rsp_col_in;
   logic [DATA_WIDTH-1:0] rsp_val_ff, rsp_val_in;
   logic                  rsp_done_ff, rsp_done_in;

   logic                  ram_we;
   logic                  ram_re;
   logic [DATA_WIDTH-1:0] ram_rdata;
   alu_op_type            alu_op;
   logic [DATA_WIDTH-1:0] alu_a;
   logic [DATA_WIDTH-1:0] alu_b;
   logic [DATA_WIDTH-1:0] alu_y;

   // accumulator store, one entry per column
   scr_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (MAX_COLUMNS)
   ) u_acc_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (col_ff),
      .wdata (acc_ff),
      .re    (ram_re),
      .raddr (col_pos_ff),
      .rdata (ram_rdata)
   );

   // the one arithmetic unit
   scr_alu u_alu (
      .op (alu_op),
      .a  (alu_a),
      .b  (alu_b),
      .y  (alu_y)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         col_pos_ff   <= '0;
         row_pos_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_pos_ff   <= col_pos_in;
         row_pos_ff   <= row_pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      col_ff      <= col_in;
      last_col_ff <= last_col_in;
      last_row_ff <= last_row_in;
      row_zero_ff <= row_zero_in;
      v_ff        <= v_in;
      prior_ff    <= prior_in;
      acc_ff      <= acc_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_val_ff  <= rsp_val_in;
      rsp_done_ff <= rsp_done_in;
   end

   // sequencer: next state, unit operands and register updates
   always_comb begin
      state_in     = state_ff;
      col_pos_in   = col_pos_ff;
      row_pos_in   = row_pos_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      col_in       = col_ff;
      last_col_in  = last_col_ff;
      last_row_in  = last_row_ff;
      row_zero_in  = row_zero_ff;
      v_in         = v_ff;
      prior_in     = prior_ff;
      acc_in       = acc_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_val_in   = rsp_val_ff;
      rsp_done_in  = rsp_done_ff;
      req_ready    = 1'b0;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      alu_op       = ALU_ADD;
      alu_a        = acc_ff;
      alu_b        = v_ff;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ram_re      = 1'b1;
               col_in      = col_pos_ff;
               last_col_in = (col_pos_ff >= cfg.cols_m1);
               last_row_in = (row_pos_ff >= cfg.rows_m1);
               row_zero_in = (row_pos_ff == '0);
               v_in        = req_partial;
               prior_in    = req_prior;
               // advance the column and row position
               if (col_pos_ff >= cfg.cols_m1) begin
                  col_pos_in = '0;
                  row_pos_in = (row_pos_ff >= cfg.rows_m1) ? '0 : row_pos_ff + 1'b1;
               end else begin
                  col_pos_in = col_pos_ff + 1'b1;
               end
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            // first row starts from the identity
            acc_in   = row_zero_ff ? identity_of(cfg.reduce_op) : ram_rdata;
            state_in = (cfg.reduce_op == RED_SQADD) ? ST_SQUARE : ST_FOLD;
         end
         ST_SQUARE: begin
            alu_op   = ALU_MUL;
            alu_a    = v_ff;
            alu_b    = v_ff;
            v_in     = alu_y;
            state_in = ST_FOLD;
         end
         ST_FOLD: begin
            alu_op   = fold_op_of(cfg.reduce_op);
            acc_in   = alu_y;
            state_in = ST_STORE;
         end
         ST_STORE: begin
            // write back and scale in the same cycle
            ram_we = 1'b1;
            alu_op = ALU_MUL;
            alu_b  = cfg.scale;
            if (last_row_ff) begin
               acc_in   = alu_y;
               state_in = cfg.accumulate ? ST_UPDATE : ST_EMIT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_UPDATE: begin
            alu_op   = ALU_ADD;
            alu_b    = prior_ff;
            acc_in   = alu_y;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_col_in   = col_ff;
               rsp_val_in   = acc_ff;
               rsp_done_in  = last_col_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_column = rsp_col_ff;
   assign rsp_result = rsp_val_ff;
   assign rsp_done   = rsp_done_ff;

endmodule

`default_nettype wire

FILE: rtl/scr_checker.sv
`default_nettype none

module scr_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_valid,
   input wire logic                              req_ready,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_ready,
   input wire logic [scr_pkg::COL_W-1:0]         column_index,
   input wire logic [scr_pkg::DATA_WIDTH-1:0]    result_value,
   input wire logic                              batch_done
);

   // a stalled result stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // a stalled result holds its word
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         $stable(column_index) && $stable(result_value) && $stable(batch_done))
      else $error("stalled result changed");

   // the sequencer is busy right after taking a word
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("word taken while busy");

   // no result is offered right after reset
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind strided_column_reduction_top scr_checker u_scr_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .column_index (rsp_chan.column_index),
   .result_value (rsp_chan.result_value),
   .batch_done   (rsp_chan.batch_done)
);

`default_nettype wire

FILE: verif/tb_strided_column_reduction_top.sv
`default_nettype none

module tb_strided_column_reduction_top;
   import scr_pkg::*;

   localparam int RANDOM_WORDS = 950;
   localparam int SETTLE_CYCLES = 16;
   localparam int RUN_LIMIT = 1_000_000;
   localparam int REPORT_LIMIT = 10;
   localparam logic [CSR_INDEX_W-1:0] CSR_TOP_INDEX = '1;

   // one expected or observed column result
   typedef struct packed {
      logic [COL_W-1:0]      column;
      logic [DATA_WIDTH-1:0] value;
      logic                  done;
   } column_result_type;

   // column reduction predictor and result checker
   class reduction_scoreboard;
      logic [OP_W-1:0]       reduce_op;
      logic [CCOUNT_W-1:0]   column_count;
      logic [ROW_W-1:0]      row_count;
      logic [DATA_WIDTH-1:0] scale_factor;
      logic                  accumulate;
      logic [DATA_WIDTH-1:0] accum [MAX_COLUMNS];
      bit                    started [MAX_COLUMNS];
      logic [COL_W-1:0]      column_pos;
      logic [ROW_W-1:0]      row_pos;
      column_result_type     expected_columns [$];
      int unsigned           words_taken;
      int unsigned           batches_closed;
      int unsigned           failures;

      function new();
         reduce_op = RED_ADD;
         column_count = CCOUNT_W'(1);
         row_count = ROW_W'(1);
         scale_factor = DATA_WIDTH'(1);
         accumulate = 1'b0;
         column_pos = '0;
         row_pos = '0;
         words_taken = 0;
         batches_closed = 0;
         failures = 0;
         foreach (started[i]) started[i] = 1'b0;
      endfunction

      function void set_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_REDUCE_OP:    reduce_op = data[OP_W-1:0];
            CSR_COLUMN_COUNT: column_count = data[CCOUNT_W-1:0];
            CSR_ROW_COUNT:    row_count = data[ROW_W-1:0];
            CSR_SCALE_FACTOR: scale_factor = data[DATA_WIDTH-1:0];
            CSR_ACCUM_MODE:   accumulate = data[0];
            default: ;
         endcase
      endfunction

      // zero means one, anything past the array saturates
      function int unsigned clamp_columns(logic [CCOUNT_W-1:0] c);
         if (c == 0) return 1;
         if (c > MAX_COLUMNS) return MAX_COLUMNS;
         return 32'(c);
      endfunction

      function int unsigned effective_rows();
         return (row_count == 0) ? 1 : 32'(row_count);
      endfunction

      // number of accumulators started since reset, counted from column zero
      function int unsigned started_prefix();
         int unsigned n;
         n = 0;
         while (n < MAX_COLUMNS && started[n]) n++;
         return n;
      endfunction

      function logic [DATA_WIDTH-1:0] start_value();
         case (reduce_op)
            RED_MUL:  return 1;
            RED_MAX:  return {1'b1, {(DATA_WIDTH-1){1'b0}}};
            RED_MIN:  return {1'b0, {(DATA_WIDTH-1){1'b1}}};
            RED_LAND: return 1;
            default:  return '0;
         endcase
      endfunction

      function logic [DATA_WIDTH-1:0] fold_in(logic [DATA_WIDTH-1:0] acc,
                                              logic [DATA_WIDTH-1:0] v);
         case (reduce_op)
            RED_SQADD: return acc + v * v;
            RED_MUL:   return acc * v;
            RED_MAX:   return ($signed(acc) < $signed(v)) ? v : acc;
            RED_MIN:   return ($signed(v) < $signed(acc)) ? v : acc;
            RED_LAND:  return DATA_WIDTH'((acc != 0) && (v != 0));
            RED_LOR:   return DATA_WIDTH'((acc != 0) || (v != 0));
            default:   return acc + v;
         endcase
      endfunction

      // fold one accepted word, queue a result on the last row
      function void note_word(logic [DATA_WIDTH-1:0] partial, logic [DATA_WIDTH-1:0] prior);
         int unsigned       cols;
         int unsigned       rows;
         logic [DATA_WIDTH-1:0] acc;
         logic [DATA_WIDTH-1:0] res;
         bit                last_col;
         bit                last_row;
         column_result_type r;
         cols = clamp_columns(column_count);
         rows = effective_rows();
         last_col = column_pos >= cols - 1;
         last_row = row_pos >= rows - 1;
         acc = (row_pos == 0) ? start_value() : accum[column_pos];
         acc = fold_in(acc, partial);
         accum[column_pos] = acc;
         started[column_pos] = 1'b1;
         words_taken++;
         if (last_row) begin
            res = acc * scale_factor;
            if (accumulate) res = res + prior;
            r.column = column_pos;
            r.value = res;
            r.done = last_col;
            expected_columns.push_back(r);
            if (last_col) batches_closed++;
         end
         if (last_col) begin
            column_pos = '0;
            row_pos = last_row ? '0 : row_pos + 1'b1;
         end else begin
            column_pos = column_pos + 1'b1;
         end
      endfunction

      // compare one accepted result with the oldest expectation
      function void check_column(logic [COL_W-1:0] column, logic [DATA_WIDTH-1:0] value,
                                 logic done);
         column_result_type want;
         if (expected_columns.size() == 0) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display("unexpected result: col %0d value %0d done %0b",
                        column, $signed(value), done);
            return;
         end
         want = expected_columns.pop_front();
         if (want.column !== column || want.value !== value || want.done !== done) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display("mismatch: want col %0d val %0d done %0b, got col %0d val %0d done %0b",
                        want.column, $signed(want.value), want.done,
                        column, $signed(value), done);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   scr_req_if req_bus ();
   scr_rsp_if rsp_bus ();

   reduction_scoreboard board = new();
   int unsigned burst_left = 0;
   int unsigned wide_batches = 0;
   logic [31:0] stall_pattern = '1;
   logic [4:0] pattern_step = '0;

   strided_column_reduction_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #1 clock = ~clock;

   // mix of extremes, small values and full random words
   function automatic logic [DATA_WIDTH-1:0] random_word();
      case ($urandom_range(0, 7))
         0: return {1'b1, {(DATA_WIDTH-1){1'b0}}};
         1: return {1'b0, {(DATA_WIDTH-1){1'b1}}};
         2: return '0;
         3: return $urandom_range(0, 6) - 3;
         default: return $urandom;
      endcase
   endfunction

   // register write, one cycle of write enable
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      board.set_reg(idx, data);
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // offer one word, bursts separated by random gaps
   task automatic send_word(input logic [DATA_WIDTH-1:0] partial,
                            input logic [DATA_WIDTH-1:0] prior);
      int unsigned gap;
      @(negedge clock);
      if (burst_left == 0) begin
         req_bus.valid = 1'b0;
         gap = $urandom_range(1, 6);
         repeat (gap) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
                                                   : $urandom_range(1, 12);
      end
      req_bus.valid = 1'b1;
      req_bus.partial_value = partial;
      req_bus.prior_output = prior;
      do @(posedge clock); while (!req_bus.ready);
      board.note_word(partial, prior);
      burst_left--;
   endtask

   // hold off until every result is in, then let the block settle
   task automatic wait_drained();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (board.expected_columns.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // extremes, every operation and the count corner cases
   task automatic directed_words();
      write_reg(CSR_SCALE_FACTOR, 1);
      send_word({1'b0, {(DATA_WIDTH-1){1'b1}}}, {1'b1, {(DATA_WIDTH-1){1'b0}}});
      send_word({1'b1, {(DATA_WIDTH-1){1'b0}}}, {1'b0, {(DATA_WIDTH-1){1'b1}}});
      wait_drained();
      // update mode with the most negative scale
      write_reg(CSR_ACCUM_MODE, 1);
      write_reg(CSR_SCALE_FACTOR, {1'b1, {(DATA_WIDTH-1){1'b0}}});
      send_word('1, {1'b0, {(DATA_WIDTH-1){1'b1}}});
      wait_drained();
      // zero column and row counts act as one
      write_reg(CSR_COLUMN_COUNT, 0);
      write_reg(CSR_ROW_COUNT, 0);
      send_word(32'h1234_5678, {1'b1, {(DATA_WIDTH-1){1'b0}}});
      wait_drained();
      // each operation over two rows, the unused selector too
      write_reg(CSR_ROW_COUNT, 2);
      for (int k = RED_ADD; k <= RED_LOR + 1; k++) begin
         write_reg(CSR_REDUCE_OP, k);
         write_reg(CSR_SCALE_FACTOR, k[0] ? '1 : {1'b0, {(DATA_WIDTH-1){1'b1}}});
         write_reg(CSR_ACCUM_MODE, CSR_DATA_W'(k[1]));
         send_word(k[0] ? {1'b1, {(DATA_WIDTH-1){1'b0}}} : '0, $urandom);
         send_word(32'hffff_fff0 + k, $urandom);
         wait_drained();
      end
   endtask

   // new settings between phases, possibly in the middle of a batch
   task automatic reconfigure();
      logic [31:0] cand;
      bit          go_wide;
      int unsigned prefix;
      prefix = board.started_prefix();
      if ($urandom_range(0, 2) != 0) write_reg(CSR_REDUCE_OP, $urandom);
      go_wide = board.row_pos == 0 && wide_batches < 2 &&
                ($urandom_range(0, 15) == 0 || board.words_taken > 350 * (wide_batches + 1));
      if (go_wide) begin
         // full width once, then a saturating count
         cand = (wide_batches == 0) ? MAX_COLUMNS
                                    : $urandom_range(MAX_COLUMNS + 1, (1 << CCOUNT_W) - 1);
         wide_batches++;
         write_reg(CSR_COLUMN_COUNT, cand | ($urandom << CCOUNT_W));
         write_reg(CSR_ROW_COUNT, ($urandom << ROW_W) | 1);
      end else begin
         // a wide count always goes back to a narrow one after its batch
         if (board.clamp_columns(board.column_count) > 32 || $urandom_range(0, 2) != 0) begin
            case ($urandom_range(0, 9))
               0: cand = 0;
               1: cand = $urandom_range(7, 24);
               default: cand = $urandom_range(1, 6);
            endcase
            // mid-batch, only columns that already hold a value may be read
            if (board.row_pos == 0 ||
                (board.clamp_columns(cand[CCOUNT_W-1:0]) <= prefix &&
                 board.column_pos < prefix))
               write_reg(CSR_COLUMN_COUNT, cand | ($urandom << CCOUNT_W));
         end
         if (board.effective_rows() > 8 || $urandom_range(0, 2) != 0) begin
            case ($urandom_range(0, 11))
               0: cand = 0;
               1: cand = (1 << ROW_W) - 1;
               2: cand = $urandom_range(9, (1 << ROW_W) - 2);
               default: cand = $urandom_range(1, 4);
            endcase
            write_reg(CSR_ROW_COUNT, cand | ($urandom << ROW_W));
         end
      end
      if ($urandom_range(0, 1) != 0) write_reg(CSR_SCALE_FACTOR, random_word());
      if ($urandom_range(0, 2) == 0) write_reg(CSR_ACCUM_MODE, $urandom);
      if ($urandom_range(0, 7) == 0)
         write_reg(CSR_INDEX_W'($urandom_range(CSR_ACCUM_MODE + 1, CSR_TOP_INDEX)), $urandom);
   endtask

   // whole batches most of the time, a partial run otherwise
   task automatic run_phase();
      int unsigned goal;
      int unsigned count;
      if (board.effective_rows() <= 8 && $urandom_range(0, 3) != 0) begin
         goal = board.batches_closed +
                ((board.clamp_columns(board.column_count) > 32) ? 1 : $urandom_range(1, 3));
         while (board.batches_closed < goal) send_word(random_word(), random_word());
      end else begin
         count = $urandom_range(1, 12);
         repeat (count) send_word(random_word(), random_word());
      end
   endtask

   // result receiver stalls on its own pattern
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (pattern_step == 0) begin
            case ($urandom_range(0, 3))
               0: stall_pattern = '1;
               1: stall_pattern = $urandom;
               2: stall_pattern = $urandom | $urandom;
               default: stall_pattern = $urandom & $urandom;
            endcase
         end
         rsp_bus.ready = stall_pattern[pattern_step];
         pattern_step = pattern_step + 1'b1;
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         board.check_column(rsp_bus.column_index, rsp_bus.result_value, rsp_bus.batch_done);
   end

   // main sequence
   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_bus.valid = 1'b0;
      req_bus.partial_value = '0;
      req_bus.prior_output = '0;
      repeat (8) @(negedge clock);
      reset = 1'b0;
      directed_words();
      while (board.words_taken < RANDOM_WORDS + 20) begin
         reconfigure();
         run_phase();
         wait_drained();
      end
      if (board.failures == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // run limit
   initial begin
      #(RUN_LIMIT);
      $display("Mismatches found");
      $finish;
   end

endmodule

`default_nettype wire

FILE: strided_column_reduction_top.f
rtl/scr_pkg.sv
rtl/scr_channels.sv
rtl/scr_ram.sv
rtl/scr_alu.sv
rtl/scr_seq.sv
rtl/strided_column_reduction_top.sv
rtl/scr_checker.sv
verif/tb_strided_column_reduction_top.sv
